### rtl/psg_pkg.sv
`default_nettype none

package psg_pkg;

    // Sizes of the permutation store
    localparam int MAX_ELEMENTS = 8;
    localparam int ELEM_W       = $clog2(MAX_ELEMENTS);
    localparam int NUM_W        = 4;
    localparam int PERM_W       = MAX_ELEMENTS * ELEM_W;
    localparam int IDX_W        = 16;
    localparam int ADV_W        = 8;
    localparam logic [NUM_W-1:0] RESET_ELEMENTS = NUM_W'(4);

    // Factorials of 0 through MAX_ELEMENTS
    localparam logic [IDX_W-1:0] FACT_TAB [0:8] = '{
        16'd1, 16'd1, 16'd2, 16'd6, 16'd24, 16'd120, 16'd720, 16'd5040, 16'd40320
    };

    // Direction codes per element
    typedef enum logic [1:0] {
        DIR_STOP  = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_LEFT  = 2'd2
    } t_dir;

    // Commands from controller to datapath
    typedef struct packed {
        logic start;
        logic step;
        logic load;
    } t_dp_cmd;

    // Clamp the register value to the supported element count
    function automatic logic [NUM_W-1:0] active_n(input logic [NUM_W-1:0] raw);
        logic [NUM_W-1:0] res;
        res = raw;
        if (raw == '0) begin
            res = NUM_W'(1);
        end else if (raw > NUM_W'(MAX_ELEMENTS)) begin
            res = NUM_W'(MAX_ELEMENTS);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/psg_ctrl.sv
`default_nettype none

module psg_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire logic [psg_pkg::ADV_W-1:0] i_advance_count,
    output logic                           o_ready,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output psg_pkg::t_dp_cmd               o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    t_state                    r_state;
    logic [psg_pkg::ADV_W-1:0] r_remain;
    logic                      r_out_valid;
    logic                      accept;
    logic                      out_free;

    assign o_ready  = (r_state == ST_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign o_valid  = r_out_valid;

    // Issue datapath commands
    assign o_cmd.start = accept;
    assign o_cmd.step  = (r_state == ST_RUN);
    assign o_cmd.load  = (r_state == ST_DONE) && out_free;

    // Sequence one request: take it, step it, hand the result over
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_remain    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && !o_cmd.load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_remain <= i_advance_count;
                        r_state  <= (i_advance_count == '0) ? ST_DONE : ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_remain <= r_remain - psg_pkg::ADV_W'(1);
                    if (r_remain == psg_pkg::ADV_W'(1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/psg_dp.sv
`default_nettype none

module psg_dp (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [psg_pkg::NUM_W-1:0]  i_elements_in_use,
    input  wire psg_pkg::t_dp_cmd           i_cmd,
    output logic [psg_pkg::PERM_W-1:0]      o_perm_packed,
    output logic                            o_step_status,
    output logic [psg_pkg::IDX_W-1:0]       o_perm_index
);

    localparam int N  = psg_pkg::MAX_ELEMENTS;
    localparam int EW = psg_pkg::ELEM_W;
    localparam int NW = psg_pkg::NUM_W;
    localparam int CW = psg_pkg::IDX_W;

    // Permutation state
    logic [EW-1:0]   r_val [N];
    psg_pkg::t_dir   r_dir [N];
    logic [CW-1:0]   r_cnt;
    logic            r_stat;
    logic [NW-1:0]   r_elem;
    logic [EW-1:0]   n_val [N];
    psg_pkg::t_dir   n_dir [N];
    logic [CW-1:0]   n_cnt;
    logic            n_stat;

    // Output registers
    logic [psg_pkg::PERM_W-1:0] r_out_packed;
    logic                       r_out_stat;
    logic [CW-1:0]              r_out_idx;

    // Step working signals
    logic [NW-1:0]              act_n;
    logic [CW-1:0]              limit;
    logic [CW-1:0]              cnt_inc;
    logic                       found;
    logic [EW-1:0]              best;
    logic [EW-1:0]              mx;
    logic                       go_left;
    logic                       at_edge;
    logic                       outer;
    logic [EW-1:0]              tgt;
    logic [EW-1:0]              beyond;
    logic [psg_pkg::PERM_W-1:0] packed_now;

    assign act_n   = psg_pkg::active_n(r_elem);
    assign limit   = psg_pkg::FACT_TAB[act_n];
    assign cnt_inc = r_cnt + CW'(1);

    // Scan for the largest mobile element
    always_comb begin
        found = 1'b0;
        best  = '0;
        mx    = '0;
        for (int i = 0; i < N; i++) begin
            if ((NW'(i) < act_n) &&
                (r_dir[i] == psg_pkg::DIR_LEFT || r_dir[i] == psg_pkg::DIR_RIGHT) &&
                (!found || r_val[i] > mx)) begin
                found = 1'b1;
                best  = EW'(i);
                mx    = r_val[i];
            end
        end
    end

    // Mover geometry
    assign go_left = (r_dir[best] == psg_pkg::DIR_LEFT);
    assign at_edge = go_left ? (best == '0) : ({1'b0, best} == act_n - NW'(1));
    assign outer   = go_left ? (best == EW'(1)) : ({1'b0, best} == act_n - NW'(2));
    assign tgt     = go_left ? best - EW'(1) : best + EW'(1);
    assign beyond  = go_left ? best - EW'(2) : best + EW'(2);

    // Next state: restart, clear status, or take one step
    always_comb begin
        n_val  = r_val;
        n_dir  = r_dir;
        n_cnt  = r_cnt;
        n_stat = r_stat;
        if (i_cfg_we) begin
            for (int i = 0; i < N; i++) begin
                n_val[i] = EW'(i);
                n_dir[i] = psg_pkg::DIR_LEFT;
            end
            n_dir[0] = psg_pkg::DIR_STOP;
            n_cnt    = CW'(1);
        end else if (i_cmd.start) begin
            n_stat = 1'b0;
        end else if (i_cmd.step) begin
            if (r_cnt > limit) begin
                n_stat = 1'b1;
            end else begin
                n_cnt = cnt_inc;
                if (cnt_inc > limit) begin
                    n_stat = 1'b1;
                end else begin
                    n_stat = 1'b0;
                    if (found) begin
                        // Swap the mover toward its direction
                        if (!at_edge) begin
                            n_val[best] = r_val[tgt];
                            n_val[tgt]  = mx;
                            n_dir[best] = r_dir[tgt];
                            if (outer || r_val[beyond] > mx) begin
                                n_dir[tgt] = psg_pkg::DIR_STOP;
                            end else begin
                                n_dir[tgt] = r_dir[best];
                            end
                        end
                        // Re-enable larger elements around the old position
                        for (int i = 0; i < N; i++) begin
                            if ((NW'(i) < act_n) && (n_val[i] > mx)) begin
                                if (EW'(i) < best) begin
                                    n_dir[i] = psg_pkg::DIR_RIGHT;
                                end else if (EW'(i) > best) begin
                                    n_dir[i] = psg_pkg::DIR_LEFT;
                                end
                            end
                        end
                    end
                end
            end
        end
    end

    // Pack elements in use, zero above
    always_comb begin
        packed_now = '0;
        for (int i = 0; i < N; i++) begin
            if (NW'(i) < act_n) begin
                packed_now[EW*i +: EW] = r_val[i];
            end
        end
    end

    // Hold permutation state and element count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) begin
                r_val[i] <= EW'(i);
                r_dir[i] <= psg_pkg::DIR_LEFT;
            end
            r_dir[0] <= psg_pkg::DIR_STOP;
            r_cnt    <= CW'(1);
            r_stat   <= 1'b0;
            r_elem   <= psg_pkg::RESET_ELEMENTS;
        end else begin
            r_val  <= n_val;
            r_dir  <= n_dir;
            r_cnt  <= n_cnt;
            r_stat <= n_stat;
            if (i_cfg_we) begin
                r_elem <= i_elements_in_use;
            end
        end
    end

    // Capture the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_packed <= packed_now;
            r_out_stat   <= r_stat;
            r_out_idx    <= r_cnt;
        end
    end

    assign o_perm_packed = r_out_packed;
    assign o_step_status = r_out_stat;
    assign o_perm_index  = r_out_idx;

endmodule

`default_nettype wire

### rtl/permutation_step_generator.sv
// A request steps the permutation once per advance_count in ST_RUN, then ST_DONE loads the result
// and raises o_valid once the output is free; one request at a time, one permutation step per cycle,
// set by the combinational largest-mobile-element scan and swap in the datapath.
// The next request is taken while a finished result still waits on the output.
// Reset (i_rst_n low, synchronous): 4 elements, identity permutation, all pointing left
// with element 0 stopped, index 1, no result pending.
`default_nettype none

module permutation_step_generator (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [psg_pkg::NUM_W-1:0]  i_elements_in_use,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [psg_pkg::ADV_W-1:0]  i_advance_count,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [psg_pkg::PERM_W-1:0]      o_perm_packed,
    output logic                            o_step_status,
    output logic [psg_pkg::IDX_W-1:0]       o_perm_index
);

    psg_pkg::t_dp_cmd cmd;

    psg_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_advance_count (i_advance_count),
        .o_ready         (o_ready),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_cmd           (cmd)
    );

    psg_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_elements_in_use (i_elements_in_use),
        .i_cmd             (cmd),
        .o_perm_packed     (o_perm_packed),
        .o_step_status     (o_step_status),
        .o_perm_index      (o_perm_index)
    );

endmodule

`default_nettype wire

### rtl/psg_checker.sv
`default_nettype none

module psg_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_valid,
    input wire logic                       o_ready,
    input wire logic                       o_valid,
    input wire logic                       i_ready,
    input wire logic                       o_step_status,
    input wire logic [psg_pkg::IDX_W-1:0]  o_perm_index
);

    // A pending result stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    // One request at a time: ready drops right after a request is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready stayed high after a request");

    // The permutation index is one-based
    a_index_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_perm_index != '0)
        else $error("zero permutation index");

    // Overflow can only be reported past the first permutation
    a_overflow_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_step_status |-> o_perm_index != psg_pkg::IDX_W'(1))
        else $error("overflow reported at index one");

endmodule

bind permutation_step_generator psg_checker u_psg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_step_status (o_step_status),
    .o_perm_index  (o_perm_index)
);

`default_nettype wire
